>>> rtl/ncd_pkg.sv
// Shared widths and command codes for the NTP clock discipline block.
package ncd_pkg;

  localparam int unsigned DVD_W = 96;
  localparam int unsigned DVS_W = 48;
  localparam int unsigned QUO_W = 57;
  localparam int unsigned MUL_A_W = 64;
  localparam int unsigned MUL_B_W = 32;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_OFFSET = 3'd1,
    CMD_SLEW   = 3'd2,
    CMD_FREQ   = 3'd3,
    CMD_MAXERR = 3'd4
  } cmd_t;

endpackage

>>> rtl/ncd_div.sv
// Bit-serial restoring divider with quotient saturation at 2^56.
module ncd_div
  import ncd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quot
);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [QUO_W-1:0] q_r;
  logic             sat_r;
  logic [6:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   r2;
  logic             ge;
  logic [QUO_W-1:0] qsh;

  assign r2   = {rem_r, dvd_r[DVD_W-1]};
  assign ge   = r2 >= {1'b0, dvs_r};
  assign qsh  = {q_r[QUO_W-2:0], ge};
  assign done = done_r;
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'(DVD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The quotient stops at 2^56 once it gets there.
  always_ff @(posedge clk) begin
    if (go) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      sat_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= ge ? DVS_W'(r2 - {1'b0, dvs_r}) : r2[DVS_W-1:0];
      if (!sat_r) begin
        if (qsh[QUO_W-1]) begin
          q_r   <= {1'b1, {(QUO_W-1){1'b0}}};
          sat_r <= 1'b1;
        end else begin
          q_r <= qsh;
        end
      end
    end
  end

endmodule

>>> rtl/ncd_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module ncd_mul
  import ncd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [MUL_A_W-1:0]         a,
  input  logic [MUL_B_W-1:0]         b,
  output logic                       done,
  output logic [MUL_A_W+MUL_B_W-1:0] prod
);

  logic [MUL_A_W-1:0]         a_r;
  logic [MUL_A_W+MUL_B_W-1:0] prod_r;
  logic [4:0]                 cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [MUL_A_W:0]           sum;

  assign sum  = {1'b0, prod_r[MUL_A_W+MUL_B_W-1:MUL_B_W]} +
                (prod_r[0] ? {1'b0, a_r} : '0);
  assign done = done_r;
  assign prod = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(MUL_B_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      a_r    <= a;
      prod_r <= {{MUL_A_W{1'b0}}, b};
    end else if (busy_r) begin
      prod_r <= {sum, prod_r[MUL_B_W-1:1]};
    end
  end

endmodule

>>> rtl/ntp_clock_discipline.sv
// Top level of the NTP kernel-style clock discipline (PLL/FLL, slew, max error, leap).
//
// Items enter on the in_ stream: the command in in_tuser, the value and second of
// day in in_tdata. Every item gives exactly one result item on the out_ stream,
// which carries the whole discipline state after the item has been applied.
// Loop settings are written through the APB-style cfg_ port; the user must write
// them only while idle, as the block itself does not enforce it. The block works
// on one item at a time. A tick in PLL mode that reports the residual in microseconds
// goes through the 96-step serial divider for that report. An offset measurement in
// PLL mode makes up to two passes through the divider (FLL term, then PLL term) and
// a 32-step serial multiply before the PLL term's divide. Other commands use neither.
// The result sits in an output register, so a new item is taken while an
// earlier result waits; if the receiver stalls, the finished next result waits
// in the block and in_tready stays low until the output register frees up.
// Synchronous reset puts the state to its reset values: zero phase and
// frequency, max error at 16 s with unsync set, leap machine in its ok state.
module ntp_clock_discipline
  import ncd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,   // value[31:0], day_second[48:32], zero pad
  input  logic [2:0]   in_tuser,   // cmd[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [199:0] out_tdata,  // freq_word[25:0], pll_slew[89:26], slew_us[99:90],
                                   // slew_remaining[131:100], offset_report[163:132],
                                   // max_error[187:164], unsync[188], fll_active[189],
                                   // leap_state[192:190], leap_step[194:193], zero pad
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MEAS, S_FLLDIV, S_MUL, S_PLLDIV, S_REPDIV, S_OUT
  } st_t;

  typedef enum logic [2:0] {
    LP_OK = 3'd0, LP_INS = 3'd1, LP_DEL = 3'd2, LP_IN = 3'd3, LP_WAIT = 3'd4
  } leap_t;

  localparam logic [1:0]  REG_MODE = 2'd0;
  localparam logic [1:0]  REG_TC   = 2'd1;
  localparam logic [1:0]  REG_SHIFT = 2'd2;
  localparam logic [1:0]  REG_LEAP = 2'd3;
  localparam logic [63:0] I64_MAX  = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] I64_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [25:0] FREQ_LIM = 26'd32768000;
  localparam logic [23:0] ERR_LIM  = 24'd16000000;
  localparam logic [9:0]  SLEW_LIM = 10'd500;
  localparam logic [16:0] DAY_SEC  = 17'd86400;
  localparam logic [1:0]  STEP_INS = 2'b11;
  localparam logic [1:0]  STEP_DEL = 2'b01;
  localparam logic [DVS_W-1:0] REP_DVS = DVS_W'(1000) << 32;

  // State and settings.
  st_t          st_r;
  leap_t        leap_r, leap_nxt;
  logic [5:0]   mode_r;
  logic [3:0]   tc_r;
  logic [2:0]   shift_r;
  logic [1:0]   leapreq_r;
  logic [2:0]   cmd_r;
  logic [31:0]  val_r;
  logic [16:0]  ds_r;
  logic [63:0]  phase_r;
  logic [25:0]  freq_r;
  logic [31:0]  ivl_r;
  logic [31:0]  pend_r, pend_nxt;
  logic [9:0]   snow_r, snow_nxt;
  logic [63:0]  sfrac_r;
  logic [23:0]  err_r, err_nxt;
  logic         unsync_r, unsync_nxt;
  logic         fll_r;
  logic [31:0]  offset_r;
  logic [31:0]  rem_r;
  logic [1:0]   step_r, step_nxt;
  logic [41:0]  ns_r;
  logic [47:0]  dfll_r;
  logic         nqneg_r;
  logic         fllneg_r;
  logic [QUO_W-1:0] fllq_r;
  logic         out_valid_r;
  logic [199:0] out_data_r;

  // Serial unit controls.
  logic             div_go_r, div_done;
  logic [DVD_W-1:0] div_dvd_r;
  logic [DVS_W-1:0] div_dvs_r;
  logic [QUO_W-1:0] div_q;
  logic             mul_go_r, mul_done;
  logic [MUL_A_W-1:0] mul_a_r;
  logic [MUL_B_W-1:0] mul_b_r;
  logic [MUL_A_W+MUL_B_W-1:0] mul_p;

  // Tick arithmetic.
  logic        ph_neg;
  logic [63:0] ph_mag, tk_m, tk_slew, tk_phase, tk_newmag;
  logic [4:0]  sh;
  logic [31:0] tk_ivl;
  logic [16:0] sod;
  logic        ins, del;
  logic [24:0] err_sum;

  // Measurement arithmetic.
  logic [63:0] nq, negold, a_sat, a_val, a_mag, nq_mag;
  logic [64:0] dsum;
  logic        fll_go;
  logic [31:0] lim, ivl_t, ivl_c;
  logic [5:0]  kexp;
  logic [59:0] fll_t, pll_t, f_t, tot, tmag;
  logic [43:0] tm;
  logic [25:0] freq_fin, freq_wr;
  logic [23:0] err_wr;
  logic        cfg_we;
  logic [31:0] remaining;

  function automatic logic [31:0] sat32(input logic neg, input logic [63:0] v);
    logic [31:0] r;
    if (neg) begin
      r = (v >= 64'h8000_0000) ? 32'h8000_0000 : (~v[31:0]) + 32'd1;
    end else begin
      r = (v >= 64'h7fff_ffff) ? 32'h7fff_ffff : v[31:0];
    end
    return r;
  endfunction

  ncd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go_r),
    .dividend (div_dvd_r),
    .divisor  (div_dvs_r),
    .done     (div_done),
    .quot     (div_q)
  );

  ncd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (mul_go_r),
    .a     (mul_a_r),
    .b     (mul_b_r),
    .done  (mul_done),
    .prod  (mul_p)
  );

  // The PLL slew is the residual shifted down by pll_shift plus time constant.
  assign sh        = {2'b00, shift_r} + {1'b0, tc_r};
  assign ph_neg    = phase_r[63];
  assign ph_mag    = ph_neg ? (~phase_r + 64'd1) : phase_r;
  assign tk_m      = ph_mag >> sh;
  assign tk_slew   = ph_neg ? (~tk_m + 64'd1) : tk_m;
  assign tk_phase  = phase_r - tk_slew;
  assign tk_newmag = ph_mag - tk_m;
  assign tk_ivl    = (&ivl_r) ? ivl_r : ivl_r + 32'd1;

  assign sod = (ds_r >= DAY_SEC) ? ds_r - DAY_SEC : ds_r;
  assign ins = leapreq_r[0];
  assign del = leapreq_r[1];

  // Single-shot correction is spread at most 500 us per second.
  always_comb begin
    if ($signed(pend_r) > $signed({22'd0, SLEW_LIM})) begin
      snow_nxt = SLEW_LIM;
      pend_nxt = pend_r - {22'd0, SLEW_LIM};
    end else if ($signed(pend_r) < -$signed({22'd0, SLEW_LIM})) begin
      snow_nxt = ~SLEW_LIM + 10'd1;
      pend_nxt = pend_r + {22'd0, SLEW_LIM};
    end else begin
      snow_nxt = pend_r[9:0];
      pend_nxt = '0;
    end
  end

  // Max error grows by 500 us a second; reaching the limit marks unsync.
  assign err_sum = {1'b0, err_r} + 25'd500;
  always_comb begin
    if (err_sum >= {1'b0, ERR_LIM}) begin
      err_nxt    = ERR_LIM;
      unsync_nxt = 1'b1;
    end else begin
      err_nxt    = err_sum[23:0];
      unsync_nxt = unsync_r;
    end
  end

  // Leap machine: insert steps back at midnight, delete steps forward a second early.
  always_comb begin
    leap_nxt = leap_r;
    step_nxt = 2'b00;
    case (leap_r)
      LP_OK: begin
        if (ins) leap_nxt = LP_INS;
        else if (del) leap_nxt = LP_DEL;
      end
      LP_INS: begin
        if (sod <= 17'd1) begin
          step_nxt = STEP_INS;
          leap_nxt = LP_IN;
        end else if (!ins) begin
          leap_nxt = LP_OK;
        end
      end
      LP_DEL: begin
        if (sod == DAY_SEC - 17'd1 || sod == 17'd0) begin
          step_nxt = STEP_DEL;
          leap_nxt = LP_WAIT;
        end else if (!del) begin
          leap_nxt = LP_OK;
        end
      end
      LP_IN: leap_nxt = LP_WAIT;
      default: begin
        if (!ins && !del) leap_nxt = LP_OK;
      end
    endcase
  end

  // New phase in Q32.32 ns: a microsecond offset saturates once scaled to ns.
  always_comb begin
    if (mode_r[2]) begin
      nq = {val_r, 32'd0};
    end else if ($signed(ns_r) >= 42'sd2147483648) begin
      nq = I64_MAX;
    end else if ($signed(ns_r) < -42'sd2147483648) begin
      nq = I64_MIN;
    end else begin
      nq = {ns_r[31:0], 32'd0};
    end
  end

  assign negold = (phase_r == I64_MIN) ? I64_MAX : ~phase_r + 64'd1;
  assign dsum   = {nq[63], nq} + {negold[63], negold};
  assign a_sat  = (dsum[64] != dsum[63]) ? (dsum[64] ? I64_MIN : I64_MAX) : dsum[63:0];
  assign a_val  = mode_r[4] ? a_sat : nq;
  assign a_mag  = a_val[63] ? ~a_val + 64'd1 : a_val;
  assign nq_mag = nq[63] ? ~nq + 64'd1 : nq;
  assign fll_go = (phase_r != 64'd0) && (ivl_r >= 32'd256) &&
                  (mode_r[1] || ivl_r > 32'd2048);

  assign lim   = 32'd1 << (sh + 5'd1);
  assign ivl_t = (ivl_r > 32'd2048) ? 32'd2048 : ivl_r;
  assign ivl_c = !mode_r[5] ? ivl_r : ((ivl_t > lim) ? lim : ivl_t);
  assign kexp  = {sh, 1'b0} + 6'd4;

  // Frequency update in Q16 of the frequency word.
  assign fll_t = fllneg_r ? ~{3'd0, fllq_r} + 60'd1 : {3'd0, fllq_r};
  assign pll_t = nqneg_r ? ~{3'd0, div_q} + 60'd1 : {3'd0, div_q};
  assign f_t   = {{18{freq_r[25]}}, freq_r, 16'd0};
  assign tot   = f_t + fll_t + pll_t;
  assign tmag  = tot[59] ? ~tot + 60'd1 : tot;
  assign tm    = tmag[59:16];
  always_comb begin
    if (tm > {18'd0, FREQ_LIM}) begin
      freq_fin = tot[59] ? ~FREQ_LIM + 26'd1 : FREQ_LIM;
    end else begin
      freq_fin = tot[59] ? ~tm[25:0] + 26'd1 : tm[25:0];
    end
  end

  always_comb begin
    if ($signed(val_r) > $signed({6'd0, FREQ_LIM})) begin
      freq_wr = FREQ_LIM;
    end else if ($signed(val_r) < -$signed({6'd0, FREQ_LIM})) begin
      freq_wr = ~FREQ_LIM + 26'd1;
    end else begin
      freq_wr = val_r[25:0];
    end
  end

  always_comb begin
    if (val_r[31]) begin
      err_wr = '0;
    end else if (val_r > {8'd0, ERR_LIM}) begin
      err_wr = ERR_LIM;
    end else begin
      err_wr = val_r[23:0];
    end
  end

  assign remaining = (cmd_r == CMD_SLEW) ? rem_r : pend_r;
  assign cfg_we    = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_MODE:  cfg_prdata = {26'd0, mode_r};
      REG_TC:    cfg_prdata = {28'd0, tc_r};
      REG_SHIFT: cfg_prdata = {29'd0, shift_r};
      REG_LEAP:  cfg_prdata = {30'd0, leapreq_r};
      default:   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      mode_r      <= '0;
      tc_r        <= '0;
      shift_r     <= 3'd2;
      leapreq_r   <= '0;
      phase_r     <= '0;
      freq_r      <= '0;
      ivl_r       <= '0;
      pend_r      <= '0;
      snow_r      <= '0;
      sfrac_r     <= '0;
      err_r       <= ERR_LIM;
      unsync_r    <= 1'b1;
      fll_r       <= 1'b0;
      leap_r      <= LP_OK;
      offset_r    <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
      mul_go_r    <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      mul_go_r <= 1'b0;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_paddr[3:2])
          REG_MODE: begin
            if (cfg_pwdata[0] && !mode_r[0]) ivl_r <= '0;
            mode_r <= cfg_pwdata[5:0];
          end
          REG_TC:    tc_r <= (cfg_pwdata[3:0] > 4'd10) ? 4'd10 : cfg_pwdata[3:0];
          REG_SHIFT: shift_r <= cfg_pwdata[2:0];
          REG_LEAP:  leapreq_r <= cfg_pwdata[1:0];
          default: ;
        endcase
      end

      case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r <= in_tuser;
            val_r <= in_tdata[31:0];
            ds_r  <= in_tdata[48:32];
            st_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          step_r <= 2'b00;
          st_r   <= S_OUT;
          case (cmd_r)
            CMD_TICK: begin
              if (mode_r[0]) begin
                ivl_r   <= tk_ivl;
                sfrac_r <= tk_slew;
                phase_r <= tk_phase;
                if (mode_r[2]) begin
                  offset_r <= sat32(tk_phase[63], {32'd0, tk_newmag[63:32]});
                end else begin
                  div_dvd_r <= {32'd0, tk_newmag};
                  div_dvs_r <= REP_DVS;
                  div_go_r  <= 1'b1;
                  nqneg_r   <= tk_phase[63];
                  st_r      <= S_REPDIV;
                end
              end
              snow_r   <= snow_nxt;
              pend_r   <= pend_nxt;
              err_r    <= err_nxt;
              unsync_r <= unsync_nxt;
              leap_r   <= leap_nxt;
              step_r   <= step_nxt;
            end
            CMD_OFFSET: begin
              ns_r   <= 42'($signed({{10{val_r[31]}}, val_r}) * 42'sd1000);
              dfll_r <= 48'(ivl_r) * 48'd4000;
              if (mode_r[3]) begin
                ivl_r  <= '0;
                dfll_r <= '0;
              end
              st_r <= S_MEAS;
            end
            CMD_SLEW: begin
              rem_r  <= pend_r;
              pend_r <= val_r;
            end
            CMD_FREQ:   freq_r <= freq_wr;
            CMD_MAXERR: err_r <= err_wr;
            default: ;
          endcase
        end
        S_MEAS: begin
          phase_r  <= nq;
          offset_r <= val_r;
          if (!mode_r[0]) begin
            st_r <= S_OUT;
          end else begin
            fll_r   <= fll_go;
            nqneg_r <= nq[63];
            ivl_r   <= ivl_c;
            mul_a_r <= nq_mag;
            mul_b_r <= ivl_c;
            if (fll_go) begin
              fllneg_r  <= a_val[63];
              div_dvd_r <= {32'd0, a_mag};
              div_dvs_r <= dfll_r;
              div_go_r  <= 1'b1;
              st_r      <= S_FLLDIV;
            end else begin
              fllq_r   <= '0;
              fllneg_r <= 1'b0;
              mul_go_r <= 1'b1;
              st_r     <= S_MUL;
            end
          end
        end
        S_FLLDIV: begin
          if (div_done) begin
            fllq_r   <= div_q;
            mul_go_r <= 1'b1;
            st_r     <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_done) begin
            div_dvd_r <= mul_p;
            div_dvs_r <= DVS_W'(1000) << kexp;
            div_go_r  <= 1'b1;
            st_r      <= S_PLLDIV;
          end
        end
        S_PLLDIV: begin
          if (div_done) begin
            freq_r <= freq_fin;
            ivl_r  <= '0;
            st_r   <= S_OUT;
          end
        end
        S_REPDIV: begin
          if (div_done) begin
            offset_r <= sat32(nqneg_r, {7'd0, div_q});
            st_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {5'd0, step_r, leap_r, fll_r, unsync_r, err_r, offset_r,
                            remaining, snow_r, sfrac_r, freq_r};
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // The frequency word never leaves its clamp range.
  a_freq_range: assert property (@(posedge clk) disable iff (!rst_n)
    ($signed(freq_r) <= $signed(FREQ_LIM)) && ($signed(freq_r) >= -$signed(FREQ_LIM)))
    else $error("frequency word outside its limits");

  // Once unsynchronised, only reset clears the flag.
  a_unsync_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    unsync_r |=> unsync_r)
    else $error("unsync flag cleared without reset");

  // Max error stays within 16 s.
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    err_r <= ERR_LIM)
    else $error("max error above its limit");

  // The per-second slew never exceeds 500 us either way.
  a_slew_range: assert property (@(posedge clk) disable iff (!rst_n)
    ($signed(snow_r) <= $signed(SLEW_LIM)) && ($signed(snow_r) >= -$signed(SLEW_LIM)))
    else $error("slew step above 500 us");

endmodule

>>> tb/sv/ntp_clock_discipline_checker.sv
// Checker for the NTP clock discipline: predicts each result item and compares it.
`timescale 1ns / 100ps
`default_nettype none

module ntp_clock_discipline_checker
  import ncd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [55:0]  in_tdata,
  input  wire logic [2:0]   in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [199:0] out_tdata,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  input  wire logic         cfg_pready,
  output int                fail_count,
  output int                pending
);

  localparam int REG_MODE  = 0;
  localparam int REG_TC    = 1;
  localparam int REG_SHIFT = 2;
  localparam int REG_LEAP  = 3;

  localparam int MODE_PLL   = 0;
  localparam int MODE_FLL   = 1;
  localparam int MODE_NANO  = 2;
  localparam int MODE_HOLD  = 3;
  localparam int MODE_DIFF  = 4;
  localparam int MODE_CLAMP = 5;

  localparam int          FREQ_LIMIT   = 32768000;
  localparam int unsigned ERR_LIMIT    = 16000000;
  localparam int unsigned ERR_RATE     = 500;
  localparam int          SLEW_LIMIT   = 500;
  localparam int unsigned TC_LIMIT     = 10;
  localparam int unsigned FLL_MIN_IVL  = 256;
  localparam int unsigned FLL_MAX_IVL  = 2048;
  localparam int unsigned DAY_SECONDS  = 86400;
  localparam logic [63:0] TERM_CAP     = 64'd1 << 56;
  localparam longint      PHASE_MAX    = 64'sh7fff_ffff_ffff_ffff;
  localparam longint      PHASE_MIN    = 64'sh8000_0000_0000_0000;

  typedef enum logic [2:0] {
    LEAP_OK = 3'd0, LEAP_INS = 3'd1, LEAP_DEL = 3'd2, LEAP_IN = 3'd3, LEAP_WAIT = 3'd4
  } leap_t;

  typedef struct {
    logic [25:0] freq_word;
    logic [63:0] pll_slew;
    logic [9:0]  slew_us;
    logic [31:0] slew_remaining;
    logic [31:0] offset_report;
    logic [23:0] max_error;
    logic        unsync;
    logic        fll_active;
    logic [2:0]  leap_state;
    logic [1:0]  leap_step;
  } disc_result_t;

  // Discipline state as the block should hold it.
  logic [5:0]  mode;
  logic [3:0]  tconst;
  logic [2:0]  gain_shift;
  logic [1:0]  leap_req;
  longint      phase;
  int          freq;
  int unsigned ivl;
  int          slew_pend;
  int          slew_cur;
  longint      pll_slew;
  int unsigned err_bound;
  logic        unsync;
  logic        fll_used;
  leap_t       leap;
  int          offset_val;

  disc_result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [63:0] magnitude(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  // Truncated term num * mul / div with its magnitude capped at 2^56.
  function automatic longint scaled_term(longint num, logic [31:0] mul, logic [63:0] div);
    logic [127:0] prod;
    logic [127:0] quo;
    logic [63:0]  m;
    prod = {64'd0, magnitude(num)} * {96'd0, mul};
    quo  = prod / {64'd0, div};
    m    = (quo >= {64'd0, TERM_CAP}) ? TERM_CAP : quo[63:0];
    return num < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sat_add(longint a, longint b);
    if (b > 0 && a > PHASE_MAX - b) return PHASE_MAX;
    if (b < 0 && a < PHASE_MIN - b) return PHASE_MIN;
    return a + b;
  endfunction

  function automatic int clamp_freq(longint f);
    if (f > FREQ_LIMIT) return FREQ_LIMIT;
    if (f < -FREQ_LIMIT) return -FREQ_LIMIT;
    return int'(f);
  endfunction

  function automatic int residual_report();
    logic [63:0] m;
    logic [63:0] v;
    m = magnitude(phase);
    v = mode[MODE_NANO] ? (m >> 32) : m / (64'd1000 << 32);
    if (phase < 0) return v >= 64'h8000_0000 ? 32'h8000_0000 : -int'(v[31:0]);
    return v >= 64'h7fff_ffff ? 32'h7fff_ffff : int'(v[31:0]);
  endfunction

  function automatic void reset_state();
    mode = '0; tconst = '0; gain_shift = 3'd2; leap_req = '0;
    phase = 0; freq = 0; ivl = 0; slew_pend = 0; slew_cur = 0; pll_slew = 0;
    err_bound = ERR_LIMIT; unsync = 1'b1; fll_used = 1'b0; leap = LEAP_OK;
    offset_val = 0;
  endfunction

  function automatic void write_register(int idx, logic [31:0] val);
    case (idx)
      REG_MODE: begin
        if (val[MODE_PLL] && !mode[MODE_PLL]) ivl = 0;
        mode = val[5:0];
      end
      REG_TC:    tconst = (val[3:0] > TC_LIMIT) ? 4'(TC_LIMIT) : val[3:0];
      REG_SHIFT: gain_shift = val[2:0];
      REG_LEAP:  leap_req = val[1:0];
      default: ;
    endcase
  endfunction

  // One second tick; returns the leap step taken.
  function automatic int second_tick(logic [16:0] ds);
    int unsigned sod;
    logic [63:0] m;
    int          step;
    logic        ins;
    logic        del;
    sod  = ds % DAY_SECONDS;
    step = 0;
    ins  = leap_req[0];
    del  = leap_req[1];
    if (mode[MODE_PLL]) begin
      m = magnitude(phase) >> (int'(gain_shift) + int'(tconst));
      if (ivl != 32'hffff_ffff) ivl++;
      pll_slew   = phase < 0 ? -longint'(m) : longint'(m);
      phase      = phase - pll_slew;
      offset_val = residual_report();
    end
    if (slew_pend > SLEW_LIMIT) begin
      slew_cur = SLEW_LIMIT; slew_pend -= SLEW_LIMIT;
    end else if (slew_pend < -SLEW_LIMIT) begin
      slew_cur = -SLEW_LIMIT; slew_pend += SLEW_LIMIT;
    end else begin
      slew_cur = slew_pend; slew_pend = 0;
    end
    err_bound += ERR_RATE;
    if (err_bound >= ERR_LIMIT) begin
      err_bound = ERR_LIMIT; unsync = 1'b1;
    end
    case (leap)
      LEAP_OK: begin
        if (ins) leap = LEAP_INS;
        else if (del) leap = LEAP_DEL;
      end
      LEAP_INS: begin
        if (sod <= 1) begin
          step = -1; leap = LEAP_IN;
        end else if (!ins) leap = LEAP_OK;
      end
      LEAP_DEL: begin
        if ((sod + 1) % DAY_SECONDS <= 1) begin
          step = 1; leap = LEAP_WAIT;
        end else if (!del) leap = LEAP_OK;
      end
      LEAP_IN: leap = LEAP_WAIT;
      default: if (!ins && !del) leap = LEAP_OK;
    endcase
    return step;
  endfunction

  function automatic void offset_update(int v);
    longint      nq;
    longint      ns;
    longint      old;
    longint      fll_term;
    longint      pll_term;
    longint      tot;
    longint      a;
    logic [63:0] tm;
    int unsigned lim;
    fll_term = 0;
    if (mode[MODE_HOLD]) ivl = 0;
    if (mode[MODE_NANO]) begin
      nq = longint'(v) <<< 32;
    end else begin
      ns = longint'(v) * 1000;
      if (ns > 64'sd2147483647) nq = PHASE_MAX;
      else if (ns < -64'sd2147483648) nq = PHASE_MIN;
      else nq = ns <<< 32;
    end
    offset_val = v;
    old = phase;
    phase = nq;
    if (!mode[MODE_PLL]) return;
    if (old != 0 && ivl >= FLL_MIN_IVL && (mode[MODE_FLL] || ivl > FLL_MAX_IVL)) begin
      a = mode[MODE_DIFF] ? sat_add(nq, old == PHASE_MIN ? PHASE_MAX : -old) : nq;
      fll_used = 1'b1;
      fll_term = scaled_term(a, 32'd1, 64'd4000 * 64'(ivl));
    end else begin
      fll_used = 1'b0;
    end
    if (mode[MODE_CLAMP]) begin
      lim = 32'd1 << (tconst + gain_shift + 1);
      if (ivl > FLL_MAX_IVL) ivl = FLL_MAX_IVL;
      if (ivl > lim) ivl = lim;
    end
    pll_term = scaled_term(nq, ivl, 64'd1000 << (2 * (2 + gain_shift + tconst)));
    tot = longint'(freq) * 65536 + fll_term + pll_term;
    tm = magnitude(tot) >> 16;
    freq = clamp_freq(tot < 0 ? -longint'(tm) : longint'(tm));
    ivl = 0;
  endfunction

  function automatic disc_result_t apply_item(logic [2:0] cmd, int v, logic [16:0] ds);
    disc_result_t r;
    int step;
    int remaining;
    step = 0;
    remaining = slew_pend;
    case (cmd)
      CMD_TICK:   step = second_tick(ds);
      CMD_OFFSET: offset_update(v);
      CMD_SLEW:   slew_pend = v;
      CMD_FREQ:   freq = clamp_freq(longint'(v));
      CMD_MAXERR: err_bound = (v < 0) ? 0 : ((v > int'(ERR_LIMIT)) ? ERR_LIMIT : v);
      default: ;
    endcase
    if (cmd != CMD_SLEW) remaining = slew_pend;
    r.freq_word      = freq[25:0];
    r.pll_slew       = pll_slew;
    r.slew_us        = slew_cur[9:0];
    r.slew_remaining = remaining;
    r.offset_report  = offset_val;
    r.max_error      = err_bound[23:0];
    r.unsync         = unsync;
    r.fll_active     = fll_used;
    r.leap_state     = leap;
    r.leap_step      = step[1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp, act);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    disc_result_t e;
    if (!rst_n) begin
      reset_state();
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        write_register(int'(cfg_paddr[3:2]), cfg_pwdata);
      if (in_tvalid && in_tready)
        expected_results.push_back(apply_item(in_tuser, in_tdata[31:0], in_tdata[48:32]));
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item arrived with no expectation waiting");
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          check_field("freq_word", e.freq_word, out_tdata[25:0]);
          check_field("pll_slew", e.pll_slew, out_tdata[89:26]);
          check_field("slew_us", e.slew_us, out_tdata[99:90]);
          check_field("slew_remaining", e.slew_remaining, out_tdata[131:100]);
          check_field("offset_report", e.offset_report, out_tdata[163:132]);
          check_field("max_error", e.max_error, out_tdata[187:164]);
          check_field("unsync", e.unsync, out_tdata[188]);
          check_field("fll_active", e.fll_active, out_tdata[189]);
          check_field("leap_state", e.leap_state, out_tdata[192:190]);
          check_field("leap_step", e.leap_step, out_tdata[194:193]);
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/ntp_clock_discipline_test.sv
// Testbench top for the NTP clock discipline: stimulus, stalls and final verdict.
`timescale 1ns / 100ps
`default_nettype none

module ntp_clock_discipline_test;
  import ncd_pkg::*;

  // Register byte addresses on the configuration port.
  localparam logic [3:0] ADDR_MODE  = 4'h0;
  localparam logic [3:0] ADDR_TC    = 4'h4;
  localparam logic [3:0] ADDR_SHIFT = 4'h8;
  localparam logic [3:0] ADDR_LEAP  = 4'hc;

  // Commands the block does not define; they must leave the state alone.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  // Leap requests and mode bits as written to the registers.
  localparam logic [31:0] LEAP_NONE   = 32'd0;
  localparam logic [31:0] LEAP_INSERT = 32'd1;
  localparam logic [31:0] LEAP_DELETE = 32'd2;
  localparam logic [31:0] LEAP_BOTH   = 32'd3;
  localparam logic [31:0] MODE_PLL_ONLY = 32'd1;
  localparam logic [31:0] MODE_ALL      = 32'd63;

  localparam int RANDOM_PHASES  = 10;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int HOLD_CYCLES    = 600;
  localparam int DRAIN_CYCLES   = 400;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [55:0]  in_tdata;   // value[31:0], day_second[48:32], zero pad
  logic [2:0]   in_tuser;   // cmd[2:0]
  logic         out_tvalid;
  logic         out_tready;
  logic [199:0] out_tdata;  // freq_word .. leap_step, as laid out at the block's port
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  int fail_count;
  int pending;
  int items_sent;

  // Set by the stimulus to ask the receiver for its long hold-off, and to switch
  // both sides into a stretch with no idling at all.
  bit hold_request;
  bit steady;

  ntp_clock_discipline u_top (.*);

  ntp_clock_discipline_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Run limit: far beyond the slowest correct run, even with every offset taking
  // its full divide and multiply.
  initial begin
    #50_000_000;
    $display("ntp_clock_discipline_test NOT OK");
    $finish;
  end

  // Sender gap length: mostly none or short, now and then a long one.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The receiver. Most cycles it is ready; sometimes it stalls briefly, rarely
  // in one unbroken stall, and once for a long stretch on request so that the
  // block's output register and internal result both fill and in_tready drops.
  initial begin
    int r;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready <= 1'b1;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          out_tready <= 1'b0;
          repeat ($urandom_range(20, 60)) @(negedge clk);
          out_tready <= 1'b1;
        end else begin
          out_tready <= (r < 75);
        end
      end
    end
  end

  // Register write: a setup phase, then an access phase, then an idle phase.
  // Called at a falling edge.
  task automatic write_reg(logic [3:0] addr, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Every item yields a result, so the block is idle once nothing is pending;
  // a short pause on top keeps register writes well clear of the last item.
  // The sender stops offering first, so that the last item is not taken again.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_all(logic [31:0] mode, logic [31:0] tc, logic [31:0] sh,
                           logic [31:0] leap);
    wait_idle();
    write_reg(ADDR_MODE, mode);
    write_reg(ADDR_TC, tc);
    write_reg(ADDR_SHIFT, sh);
    write_reg(ADDR_LEAP, leap);
  endtask

  // Offers one item from a falling edge and returns at the falling edge after it
  // was taken. in_tvalid stays high straight into the next item when there is no gap.
  task automatic send_item(logic [2:0] cmd, logic [31:0] value, logic [16:0] ds);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, ds, value};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
    gap = gap_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return 32'($urandom_range(0, 2000)) - 32'd1000;
      1: return 32'($urandom_range(0, 200000)) - 32'd100000;
      2: return 32'($urandom_range(0, 8000000)) - 32'd4000000;
      3: return $urandom();
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'd0;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  // Second of day: often right at the day boundary, where the leap machine acts.
  function automatic logic [16:0] pick_second();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd1;
      2: return 17'd86399;
      3: return 17'd86398;
      default: return 17'($urandom_range(0, 131071));
    endcase
  endfunction

  initial begin
    int n_ticks;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_TICK;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = ADDR_MODE;
    cfg_pwdata  = '0;
    items_sent  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. First, a tick and an offset measurement in the reset settings.
    send_item(CMD_TICK, 32'd0, 17'd0);
    send_item(CMD_OFFSET, 32'd1000, 17'd0);

    // PLL on, microsecond units: ticks follow the residual, extreme offsets
    // saturate the phase, and out-of-range writes of frequency and max error clamp.
    write_all(MODE_PLL_ONLY, 32'd0, 32'd2, LEAP_NONE);
    send_item(CMD_OFFSET, 32'd1000, 17'd0);
    send_item(CMD_TICK, 32'd0, 17'd131071);
    send_item(CMD_OFFSET, 32'h8000_0000, 17'd0);
    send_item(CMD_TICK, 32'd0, 17'd5);
    send_item(CMD_OFFSET, 32'h7fff_ffff, 17'd0);
    send_item(CMD_FREQ, 32'h7fff_ffff, 17'd0);
    send_item(CMD_FREQ, 32'h8000_0000, 17'd0);
    send_item(CMD_MAXERR, 32'hffff_fffb, 17'd0);
    send_item(CMD_MAXERR, 32'h7fff_ffff, 17'd0);
    send_item(CMD_MAXERR, 32'd0, 17'd0);
    // Single-shot slew: a load reports the old remainder, ticks drain it.
    send_item(CMD_SLEW, 32'h7fff_ffff, 17'd0);
    send_item(CMD_TICK, 32'd0, 17'd7);
    send_item(CMD_SLEW, 32'h8000_0000, 17'd0);
    send_item(CMD_TICK, 32'd0, 17'd7);
    send_item(CMD_SLEW, 32'd300, 17'd0);
    send_item(CMD_TICK, 32'd0, 17'd7);
    send_item(CMD_SPARE_LO, 32'hffff_ffff, 17'h1ffff);
    send_item(CMD_SPARE_HI, 32'd12345, 17'd0);

    // Leap second with both requests set: insert wins, then steps at midnight.
    // Time constant above its limit and every mode bit set.
    write_all(MODE_ALL, 32'd15, 32'd7, LEAP_BOTH);
    send_item(CMD_TICK, 32'd0, 17'd100);
    send_item(CMD_TICK, 32'd0, 17'd1);
    send_item(CMD_TICK, 32'd0, 17'd2);
    wait_idle();
    write_reg(ADDR_LEAP, LEAP_NONE);
    send_item(CMD_TICK, 32'd0, 17'd3);
    // Deletion: steps one second before midnight.
    wait_idle();
    write_reg(ADDR_LEAP, LEAP_DELETE);
    send_item(CMD_TICK, 32'd0, 17'd10);
    send_item(CMD_TICK, 32'd0, 17'd86398);
    send_item(CMD_TICK, 32'd0, 17'd86399);

    // Random part, in phases of fixed settings. Mostly runs of ticks closed by an
    // offset measurement, which is what moves the loop; a long run lets the
    // interval pass the lower FLL threshold. The rest is arbitrary items.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: write_all(MODE_ALL, 32'd15, 32'd7, LEAP_BOTH);
        1: write_all(32'd0, 32'd0, 32'd0, LEAP_NONE);
        2: write_all(MODE_PLL_ONLY, 32'd10, 32'd4, LEAP_INSERT);
        default: write_all($urandom_range(0, 63), $urandom_range(0, 15),
                           $urandom_range(0, 7), $urandom_range(0, 3));
      endcase
      steady = (ph == 3);
      if (ph == 5) hold_request = 1'b1;
      while (items_sent < (ph + 1) * ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 7) begin
          n_ticks = ($urandom_range(0, 14) == 0) ? $urandom_range(250, 320)
                                                 : $urandom_range(1, 20);
          repeat (n_ticks) send_item(CMD_TICK, $urandom(), pick_second());
          send_item(CMD_OFFSET, pick_value(), pick_second());
        end else begin
          send_item(3'($urandom_range(0, 7)), pick_value(), pick_second());
        end
      end
    end
    steady = 1'b0;

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ntp_clock_discipline_test OK");
    end else begin
      $display("ntp_clock_discipline_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
